// ----- src/dklru_pkg.sv -----
// Shared types and codes for the LRU page cache directory.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dklru_pkg;

    typedef enum logic [2:0] {
        MODE_INSERT    = 3'd0,
        MODE_FIND_DEV  = 3'd1,
        MODE_FIND_INO  = 3'd2,
        MODE_REMOVE    = 3'd3,
        MODE_FREE      = 3'd4,
        MODE_CLEAR_DEV = 3'd5,
        MODE_SET_MAPS  = 3'd6,
        MODE_NOP       = 3'd7
    } mode_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_CACHED    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int IN_BITS    = 243;
    localparam int IN_BYTES   = 248;
    localparam int OUT_BITS   = 52;
    localparam int OUT_BYTES  = 56;

    // first member is the top bits, so the item's first field lands lowest
    typedef struct packed {
        logic [7:0]  mapping_refs;
        logic [10:0] page_count;
        logic [9:0]  entry_index;
        logic        touch;
        logic [15:0] page_id;
        logic        once_flag;
        logic [63:0] inode_offset;
        logic [31:0] inode;
        logic        has_inode;
        logic [63:0] device_offset;
        logic [31:0] device;
        mode_t       mode;
    } in_t;

    typedef struct packed {
        logic [10:0] cached_count;
        logic        page_released;
        logic [10:0] freed_count;
        logic        found_once;
        logic [15:0] found_page;
        logic [9:0]  found_entry;
        logic [1:0]  status;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] device;
        logic [63:0] device_offset;
        logic        has_inode;
        logic [31:0] inode;
        logic [63:0] inode_offset;
        logic        once;
        logic [15:0] page;
        logic [7:0]  maps;
    } rec_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_INS_WR, S_APP1,
        S_APP2, S_UPD_WR, S_TGT_RD, S_UNLINK, S_IDX_RD, S_IDX_EXEC, S_FREE_RD,
        S_FREE_CHK, S_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_CLR_WR, OP_DISPATCH, OP_RD_SCAN, OP_CHK_SCAN,
        OP_INS_WR, OP_APP1, OP_APP2, OP_UPD_WR, OP_RD_TGT, OP_UNLINK,
        OP_IDX_EXEC, OP_RD_CUR, OP_FREE_CHK, OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  touch;
        logic  clr_last;
        logic  scan_last;
        logic  hit;
        logic  room;
        logic  need_upd;
        logic  idx_ok;
        logic  free_more;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- src/dklru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dklru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/dklru_ctrl.sv -----
// Sequencer for the page cache directory: walks each operation through
// the datapath one step at a time. Depends on dklru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dklru_ctrl import dklru_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:     if (s_tvalid) state_next = S_DISPATCH;
            S_DISPATCH: begin
                case (sts.mode)
                    MODE_INSERT, MODE_FIND_DEV, MODE_FIND_INO, MODE_CLEAR_DEV:
                        state_next = S_SCAN_RD;
                    MODE_REMOVE, MODE_SET_MAPS:
                        state_next = sts.idx_ok ? S_IDX_RD : S_FIN;
                    MODE_FREE:
                        state_next = S_FREE_RD;
                    default:
                        state_next = S_FIN;
                endcase
            end
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (sts.mode == MODE_INSERT) begin
                    if (sts.hit) state_next = S_FIN;
                    else if (sts.scan_last) state_next = sts.room ? S_INS_WR : S_FIN;
                    else state_next = S_SCAN_RD;
                end else if (sts.mode == MODE_FIND_DEV || sts.mode == MODE_FIND_INO) begin
                    if (sts.hit) begin
                        if (sts.need_upd) state_next = S_UPD_WR;
                        else state_next = sts.touch ? S_TGT_RD : S_FIN;
                    end else if (sts.scan_last) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end else begin
                    state_next = sts.scan_last ? S_FIN : S_SCAN_RD;
                end
            end
            S_INS_WR:   state_next = S_APP1;
            S_APP1:     state_next = S_APP2;
            S_APP2:     state_next = S_FIN;
            S_UPD_WR:   state_next = sts.touch ? S_TGT_RD : S_FIN;
            S_TGT_RD:   state_next = S_UNLINK;
            S_UNLINK:   state_next = S_APP1;
            S_IDX_RD:   state_next = S_IDX_EXEC;
            S_IDX_EXEC: state_next = S_FIN;
            S_FREE_RD:  state_next = sts.free_more ? S_FREE_CHK : S_FIN;
            S_FREE_CHK: state_next = S_FREE_RD;
            S_FIN:      if (sts.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op  = OP_NOP;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR:    cmd.op = OP_CLR_WR;
            S_IDLE: begin
                s_ready = 1'b1;
                cmd.op  = s_tvalid ? OP_LOAD : OP_NOP;
            end
            S_DISPATCH: cmd.op = OP_DISPATCH;
            S_SCAN_RD:  cmd.op = OP_RD_SCAN;
            S_SCAN_CHK: cmd.op = OP_CHK_SCAN;
            S_INS_WR:   cmd.op = OP_INS_WR;
            S_APP1:     cmd.op = OP_APP1;
            S_APP2:     cmd.op = OP_APP2;
            S_UPD_WR:   cmd.op = OP_UPD_WR;
            S_TGT_RD:   cmd.op = OP_RD_TGT;
            S_UNLINK:   cmd.op = OP_UNLINK;
            S_IDX_RD:   cmd.op = OP_RD_TGT;
            S_IDX_EXEC: cmd.op = OP_IDX_EXEC;
            S_FREE_RD:  cmd.op = sts.free_more ? OP_RD_CUR : OP_NOP;
            S_FREE_CHK: cmd.op = OP_FREE_CHK;
            S_FIN:      cmd.op = sts.out_free ? OP_RESULT : OP_NOP;
            default:    cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/dklru_dp.sv -----
// Datapath: entry record and LRU link memories, list head/tail, counters
// and the result register. Depends on dklru_pkg and dklru_ram.
`timescale 1ns / 1ps
`default_nettype none

module dklru_dp import dklru_pkg::*; #(
    parameter int ENTRIES = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [IN_BYTES-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_BYTES-1:0]  m_tdata,
    input  wire cmd_t                  cmd,
    output sts_t                       sts
);

    localparam int IW = $clog2(ENTRIES);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);

    in_t             in_reg;
    out_t            out_reg;
    rec_t            hold_reg;
    logic            m_valid_reg;
    logic [IW-1:0]   scan_reg, tgt_reg, free_idx_reg, fentry_reg;
    logic            free_found_reg, rel_reg, fonce_reg;
    logic [15:0]     fpage_reg;
    logic [1:0]      status_reg;
    logic [LW-1:0]   cur_reg, head_reg, tail_reg;
    logic [CW-1:0]   total_reg, freed_reg;

    rec_t            r, rec_wd, new_rec;
    logic [LW-1:0]   o, n, old_wd, new_wd;
    logic            rec_we, old_we, new_we, re, do_unlink;
    logic [IW-1:0]   rec_wa, old_wa, new_wa, raddr;
    logic            dev_eq, doff_eq, ino_eq, dup, fhit, cmatch, scan_last;
    logic [31:0]     idx32, fentry32, freed32, total32;

    dklru_ram #(.WIDTH($bits(rec_t)), .DEPTH(ENTRIES)) u_rec (
        .aclk(aclk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
        .re(re), .raddr(raddr), .rdata(r)
    );
    dklru_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_older (
        .aclk(aclk), .we(old_we), .waddr(old_wa), .wdata(old_wd),
        .re(re), .raddr(raddr), .rdata(o)
    );
    dklru_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_newer (
        .aclk(aclk), .we(new_we), .waddr(new_wa), .wdata(new_wd),
        .re(re), .raddr(raddr), .rdata(n)
    );

    assign dev_eq    = (r.device == in_reg.device);
    assign doff_eq   = (r.device_offset == in_reg.device_offset);
    assign ino_eq    = r.has_inode && (r.inode == in_reg.inode)
                       && (r.inode_offset == in_reg.inode_offset);
    assign dup       = r.valid && ((r.page == in_reg.page_id) || (dev_eq && doff_eq));
    assign fhit      = r.valid && dev_eq && ((in_reg.mode == MODE_FIND_DEV) ? doff_eq
                       : (in_reg.has_inode && ino_eq));
    assign cmatch    = r.valid && dev_eq;
    assign scan_last = (scan_reg == IW'(ENTRIES - 1));
    assign idx32     = 32'(in_reg.entry_index);

    always_comb begin
        new_rec               = '0;
        new_rec.valid         = 1'b1;
        new_rec.device        = in_reg.device;
        new_rec.device_offset = in_reg.device_offset;
        new_rec.has_inode     = in_reg.has_inode;
        new_rec.inode         = in_reg.has_inode ? in_reg.inode : 32'd0;
        new_rec.inode_offset  = in_reg.has_inode ? in_reg.inode_offset : 64'd0;
        new_rec.once          = in_reg.once_flag;
        new_rec.page          = in_reg.page_id;
        new_rec.maps          = in_reg.mapping_refs;
    end

    always_comb begin
        sts.mode      = in_reg.mode;
        sts.touch     = in_reg.touch;
        sts.clr_last  = scan_last;
        sts.scan_last = scan_last;
        sts.hit       = (in_reg.mode == MODE_INSERT) ? dup : fhit;
        sts.room      = free_found_reg || !r.valid;
        sts.need_upd  = (in_reg.mode == MODE_FIND_DEV) && in_reg.has_inode && !ino_eq;
        sts.idx_ok    = (idx32 < ENTRIES);
        sts.free_more = (cur_reg != NIL) && (32'(freed_reg) < 32'(in_reg.page_count));
        sts.out_free  = !m_valid_reg || m_tready;
    end

    // memory port control
    always_comb begin
        rec_we    = 1'b0;
        rec_wa    = scan_reg;
        rec_wd    = '0;
        old_we    = 1'b0;
        old_wa    = tgt_reg;
        old_wd    = NIL;
        new_we    = 1'b0;
        new_wa    = tgt_reg;
        new_wd    = NIL;
        re        = 1'b0;
        raddr     = scan_reg;
        do_unlink = 1'b0;
        case (cmd.op)
            OP_CLR_WR:   rec_we = 1'b1;
            OP_RD_SCAN:  re = 1'b1;
            OP_CHK_SCAN: begin
                if (in_reg.mode == MODE_CLEAR_DEV && cmatch) begin
                    rec_we    = 1'b1;
                    do_unlink = 1'b1;
                end
            end
            OP_INS_WR: begin
                rec_we = 1'b1;
                rec_wa = free_idx_reg;
                rec_wd = new_rec;
            end
            OP_APP1: begin
                old_we = 1'b1;
                old_wd = tail_reg;
                if (tail_reg != NIL) begin
                    new_we = 1'b1;
                    new_wa = tail_reg[IW-1:0];
                    new_wd = LW'(tgt_reg);
                end
            end
            OP_APP2:     new_we = 1'b1;
            OP_UPD_WR: begin
                rec_we              = 1'b1;
                rec_wa              = tgt_reg;
                rec_wd              = hold_reg;
                rec_wd.has_inode    = 1'b1;
                rec_wd.inode        = in_reg.inode;
                rec_wd.inode_offset = in_reg.inode_offset;
            end
            OP_RD_TGT: begin
                re    = 1'b1;
                raddr = tgt_reg;
            end
            OP_UNLINK:   do_unlink = 1'b1;
            OP_IDX_EXEC: begin
                rec_wa = tgt_reg;
                if (r.valid) begin
                    rec_we = 1'b1;
                    if (in_reg.mode == MODE_REMOVE) begin
                        do_unlink = 1'b1;
                    end else begin
                        rec_wd      = r;
                        rec_wd.maps = in_reg.mapping_refs;
                    end
                end
            end
            OP_RD_CUR: begin
                re    = 1'b1;
                raddr = cur_reg[IW-1:0];
            end
            OP_FREE_CHK: begin
                rec_wa = cur_reg[IW-1:0];
                if (r.maps == 8'd0) begin
                    rec_we    = 1'b1;
                    do_unlink = 1'b1;
                end
            end
            default: ;
        endcase
        if (do_unlink) begin
            if (n != NIL) begin
                old_we = 1'b1;
                old_wa = n[IW-1:0];
                old_wd = o;
            end
            if (o != NIL) begin
                new_we = 1'b1;
                new_wa = o[IW-1:0];
                new_wd = n;
            end
        end
    end

    // control state: list ends, entry count, clear sweep, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= NIL;
            tail_reg    <= NIL;
            total_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (do_unlink) begin
                if (n == NIL) tail_reg <= o;
                if (o == NIL) head_reg <= n;
                // a touch only relinks the entry; it stays cached
                if (cmd.op != OP_UNLINK) total_reg <= total_reg - CW'(1);
            end
            case (cmd.op)
                OP_CLR_WR:   scan_reg <= scan_last ? '0 : scan_reg + IW'(1);
                OP_DISPATCH: scan_reg <= '0;
                OP_CHK_SCAN: scan_reg <= scan_reg + IW'(1);
                OP_INS_WR:   total_reg <= total_reg + CW'(1);
                OP_APP1: begin
                    tail_reg <= LW'(tgt_reg);
                    if (tail_reg == NIL) head_reg <= LW'(tgt_reg);
                end
                default: ;
            endcase
            if (cmd.op == OP_RESULT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign fentry32 = 32'(fentry_reg);
    assign freed32  = 32'(freed_reg);
    assign total32  = 32'(total_reg);

    // payload
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: in_reg <= in_t'(s_tdata[IN_BITS-1:0]);
            OP_DISPATCH: begin
                free_found_reg <= 1'b0;
                freed_reg      <= '0;
                rel_reg        <= 1'b0;
                fentry_reg     <= '0;
                fpage_reg      <= '0;
                fonce_reg      <= 1'b0;
                cur_reg        <= head_reg;
                tgt_reg        <= idx32[IW-1:0];
                if ((in_reg.mode == MODE_REMOVE || in_reg.mode == MODE_SET_MAPS)
                    && !sts.idx_ok) begin
                    status_reg <= ST_NOT_FOUND;
                end else begin
                    status_reg <= ST_OK;
                end
            end
            OP_CHK_SCAN: begin
                case (in_reg.mode)
                    MODE_INSERT: begin
                        if (!r.valid && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= scan_reg;
                        end
                        if (dup) status_reg <= ST_CACHED;
                        else if (scan_last && !free_found_reg && r.valid)
                            status_reg <= ST_FULL;
                    end
                    MODE_FIND_DEV, MODE_FIND_INO: begin
                        if (fhit) begin
                            tgt_reg    <= scan_reg;
                            hold_reg   <= r;
                            fentry_reg <= scan_reg;
                            fpage_reg  <= r.page;
                            fonce_reg  <= r.once;
                        end else if (scan_last) begin
                            status_reg <= ST_NOT_FOUND;
                        end
                    end
                    MODE_CLEAR_DEV: begin
                        if (cmatch) begin
                            freed_reg <= freed_reg + CW'(1);
                            if (r.maps == 8'd0) rel_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_INS_WR: begin
                tgt_reg    <= free_idx_reg;
                fentry_reg <= free_idx_reg;
                fpage_reg  <= in_reg.page_id;
                fonce_reg  <= in_reg.once_flag;
            end
            OP_IDX_EXEC: begin
                if (!r.valid) begin
                    status_reg <= ST_NOT_FOUND;
                end else if (in_reg.mode == MODE_REMOVE) begin
                    freed_reg <= CW'(1);
                    rel_reg   <= (r.maps == 8'd0);
                end else begin
                    fentry_reg <= tgt_reg;
                end
            end
            OP_FREE_CHK: begin
                cur_reg <= n;
                if (r.maps == 8'd0) begin
                    freed_reg <= freed_reg + CW'(1);
                    rel_reg   <= 1'b1;
                end
            end
            OP_RESULT: begin
                out_reg.status        <= status_reg;
                out_reg.found_entry   <= fentry32[9:0];
                out_reg.found_page    <= fpage_reg;
                out_reg.found_once    <= fonce_reg;
                out_reg.freed_count   <= freed32[10:0];
                out_reg.page_released <= rel_reg;
                out_reg.cached_count  <= total32[10:0];
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_BYTES - OUT_BITS)'(0), out_reg};

endmodule

`default_nettype wire

// ----- src/dual_key_lru_page_cache_table_core.sv -----
// Top level of the LRU page cache directory: sequencer plus datapath.
// Depends on dklru_pkg, dklru_ctrl, dklru_dp (which uses dklru_ram).
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata: one operation request
//  m_       out  m_tvalid/m_tready   m_tdata: one result per request
//
// One request at a time. After reset a sweep clears the valid bits of all
// ENTRIES records; s_tready stays low until it ends. Insert and find scan
// the record memory entry by entry (stopping at a hit); clear device always
// scans all entries. Free walks the LRU list from its head; remove and set
// mappings go straight to entry_index. A held result does not stop the next
// request being taken, but its result waits until m_tready frees the register.
`timescale 1ns / 1ps
`default_nettype none

module dual_key_lru_page_cache_table_core import dklru_pkg::*; #(
    parameter int ENTRIES = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // mode, device, device_offset, has_inode, inode, inode_offset,
    // once_flag, page_id, touch, entry_index, page_count, mapping_refs
    input  wire logic [IN_BYTES-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status, found_entry, found_page, found_once, freed_count,
    // page_released, cached_count
    output logic      [OUT_BYTES-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    dklru_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid),
        .s_ready(s_tready), .sts(sts), .cmd(cmd)
    );

    dklru_dp #(.ENTRIES(ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cmd(cmd), .sts(sts)
    );

endmodule

`default_nettype wire
